// ===== rtl/core/mks_pkg.sv =====
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants and the key table for the 4x4 keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int ROW_COUNT       = 4;
    localparam int COL_COUNT       = 4;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int ROW_IDX_WIDTH   = $clog2(ROW_COUNT);
    localparam int COL_IDX_WIDTH   = $clog2(COL_COUNT);
    localparam int CODE_WIDTH      = 7;

    localparam logic [CFG_DATA_WIDTH-1:0] DEBOUNCE_RESET = 16'd100;
    localparam logic [CFG_DATA_WIDTH-1:0] DWELL_RESET    = 16'd25;

    // register indexes on the config port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DWELL    = 1'b1;

    typedef struct packed {
        logic [COL_COUNT-1:0]     column_drive;
        logic                     key_valid;
        logic [ROW_IDX_WIDTH-1:0] key_row;
        logic [COL_IDX_WIDTH-1:0] key_column;
        logic [CODE_WIDTH-1:0]    key_code;
    } mks_result_t;

    // ASCII layout: "123A" / "456B" / "789C" / "*0#D"
    function automatic logic [CODE_WIDTH-1:0] key_lookup(
        input logic [ROW_IDX_WIDTH-1:0] row,
        input logic [COL_IDX_WIDTH-1:0] col
    );
        logic [CODE_WIDTH-1:0] code;
        case ({row, col})
            4'h0:    code = 7'h31; // '1'
            4'h1:    code = 7'h32; // '2'
            4'h2:    code = 7'h33; // '3'
            4'h3:    code = 7'h41; // 'A'
            4'h4:    code = 7'h34; // '4'
            4'h5:    code = 7'h35; // '5'
            4'h6:    code = 7'h36; // '6'
            4'h7:    code = 7'h42; // 'B'
            4'h8:    code = 7'h37; // '7'
            4'h9:    code = 7'h38; // '8'
            4'hA:    code = 7'h39; // '9'
            4'hB:    code = 7'h43; // 'C'
            4'hC:    code = 7'h2A; // '*'
            4'hD:    code = 7'h30; // '0'
            4'hE:    code = 7'h23; // '#'
            4'hF:    code = 7'h44; // 'D'
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/mks_row_lane.sv =====
// ----------------------------------------------------------------------------
// mks_row_lane
// One row: rising-edge detect and hold-off counter, flags an accepted press.
// ----------------------------------------------------------------------------
module mks_row_lane #(
    parameter int COUNT_WIDTH = mks_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   row_level,
    input  logic [COUNT_WIDTH-1:0] debounce_ticks,
    output logic                   press
);
    import mks_pkg::*;

    logic                   prev_reg;
    logic                   prev_next;
    logic [COUNT_WIDTH-1:0] holdoff_reg;
    logic [COUNT_WIDTH-1:0] holdoff_next;
    logic                   rise;
    logic                   holdoff_zero;

    assign rise         = row_level & ~prev_reg;
    assign holdoff_zero = (holdoff_reg == '0);
    assign press        = rise & holdoff_zero;

    always_comb begin
        prev_next    = prev_reg;
        holdoff_next = holdoff_reg;
        if (advance) begin
            prev_next = row_level;
            if (rise) begin
                // any rising edge restarts the hold-off, accepted or not
                holdoff_next = debounce_ticks;
            end else if (!holdoff_zero) begin
                holdoff_next = holdoff_reg - COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= 1'b0;
            holdoff_reg <= '0;
        end else begin
            prev_reg    <= prev_next;
            holdoff_reg <= holdoff_next;
        end
    end

endmodule

// ===== rtl/core/mks_merge.sv =====
// ----------------------------------------------------------------------------
// mks_merge
// Combines the lane press flags: highest row wins, looks up the key code.
// ----------------------------------------------------------------------------
module mks_merge (
    input  logic [mks_pkg::ROW_COUNT-1:0]     press,
    input  logic [mks_pkg::COL_IDX_WIDTH-1:0] column,
    output mks_pkg::mks_result_t              result
);
    import mks_pkg::*;

    logic [ROW_IDX_WIDTH-1:0] hit_row;
    logic                     any_press;

    always_comb begin
        hit_row = '0;
        for (int i = 0; i < ROW_COUNT; i++) begin
            if (press[i]) begin
                hit_row = ROW_IDX_WIDTH'(i);
            end
        end
    end

    assign any_press = |press;

    always_comb begin
        result.column_drive = COL_COUNT'(1) << column;
        result.key_valid    = any_press;
        result.key_row      = any_press ? hit_row : '0;
        result.key_column   = any_press ? column : '0;
        result.key_code     = any_press ? key_lookup(hit_row, column) : '0;
    end

endmodule

// ===== rtl/core/matrix_keypad_scanner.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// Debounced 4x4 key matrix scanner, one tick item in, one result item out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per scan tick carrying the four sampled row levels.
//   m_ channel: one result item per input item: the one-hot column drive for
//   that tick and, when a debounced press was seen, its row, column and
//   ASCII key code (all zero otherwise).
//   cfg_ port: cfg_we/cfg_index/cfg_wdata write the debounce time (index 0)
//   and the column dwell (index 1); write only while idle. A new dwell value
//   applies at the next column reload.
//   The result is registered. Throughput is one item per cycle while
//   m_ready stays high: four row lanes work in parallel and the column/dwell
//   counter updates in the same cycle, feeding a single output register.
//   Reset clears all hold-off counters and edge history, selects column 0
//   and loads the defaults (debounce 100, dwell 25).
//   When the receiver stalls, the held result stays on the m_ ports and
//   s_ready drops until it is taken; no item is lost.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner #(
    parameter int COUNT_WIDTH = mks_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mks_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mks_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mks_pkg::ROW_COUNT-1:0]       s_row_levels,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mks_pkg::COL_COUNT-1:0]       m_column_drive,
    output logic                                m_key_valid,
    output logic [mks_pkg::ROW_IDX_WIDTH-1:0]   m_key_row,
    output logic [mks_pkg::COL_IDX_WIDTH-1:0]   m_key_column,
    output logic [mks_pkg::CODE_WIDTH-1:0]      m_key_code
);
    import mks_pkg::*;

    logic [COUNT_WIDTH-1:0]   debounce_reg;
    logic [COUNT_WIDTH-1:0]   dwell_cfg_reg;
    logic [COUNT_WIDTH-1:0]   dwell_reg;
    logic [COUNT_WIDTH-1:0]   dwell_next;
    logic [COL_IDX_WIDTH-1:0] column_reg;
    logic [COL_IDX_WIDTH-1:0] column_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    mks_result_t              result_reg;
    mks_result_t              result_comb;
    logic [ROW_COUNT-1:0]     press;
    logic                     advance;

    assign s_ready = ~m_valid_reg | m_ready;
    assign advance = s_valid & s_ready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= COUNT_WIDTH'(DEBOUNCE_RESET);
            dwell_cfg_reg <= COUNT_WIDTH'(DWELL_RESET);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg  <= COUNT_WIDTH'(cfg_wdata);
                REG_DWELL:    dwell_cfg_reg <= COUNT_WIDTH'(cfg_wdata);
                default:      ;
            endcase
        end
    end

    generate
        for (genvar g = 0; g < ROW_COUNT; g++) begin : g_lane
            mks_row_lane #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_lane (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .advance        (advance),
                .row_level      (s_row_levels[g]),
                .debounce_ticks (debounce_reg),
                .press          (press[g])
            );
        end
    endgenerate

    mks_merge u_merge (
        .press  (press),
        .column (column_reg),
        .result (result_comb)
    );

    // column scan; a dwell of 0 or 1 advances every tick
    always_comb begin
        column_next = column_reg;
        dwell_next  = dwell_reg;
        if (advance) begin
            if (dwell_reg <= COUNT_WIDTH'(1)) begin
                column_next = column_reg + COL_IDX_WIDTH'(1);
                dwell_next  = dwell_cfg_reg;
            end else begin
                dwell_next = dwell_reg - COUNT_WIDTH'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= '0;
            dwell_reg   <= COUNT_WIDTH'(DWELL_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            column_reg  <= column_next;
            dwell_reg   <= dwell_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_comb;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_column_drive = result_reg.column_drive;
    assign m_key_valid    = result_reg.key_valid;
    assign m_key_row      = result_reg.key_row;
    assign m_key_column   = result_reg.key_column;
    assign m_key_code     = result_reg.key_code;

endmodule

// ===== tb/sv/matrix_keypad_scanner_test.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_test
// Self-checking bench for the 4x4 keypad scanner. A directed plan covers reset
// state, multi-row presses, rejected bounces and the debounce/dwell extremes.
// Random phases follow, each with its own register settings and key
// press/hold/release traffic. A local scan model predicts the result items the plan does not spell out.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mks_pkg::*;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 88;
    localparam int STALL_LIMIT   = 200;
    localparam logic [0:15][7:0] KEY_LEGEND = "123A456B789C*0#D";

    typedef enum logic {PLAN_TICK, PLAN_CONFIG} plan_kind_t;

    typedef struct {
        plan_kind_t  kind;
        logic [3:0]  rows;
        logic [15:0] debounce;
        logic [15:0] dwell;
        bit          known;
        mks_result_t result;
    } plan_entry_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [ROW_COUNT-1:0]       s_row_levels;
    logic                       m_valid;
    logic                       m_ready;
    logic [COL_COUNT-1:0]       m_column_drive;
    logic                       m_key_valid;
    logic [ROW_IDX_WIDTH-1:0]   m_key_row;
    logic [COL_IDX_WIDTH-1:0]   m_key_column;
    logic [CODE_WIDTH-1:0]      m_key_code;

    // scan model state
    logic [15:0] scan_debounce;
    logic [15:0] scan_dwell;
    logic [15:0] dwell_left;
    logic [15:0] holdoff_left [ROW_COUNT];
    logic [1:0]  scan_col;
    logic [3:0]  last_rows;

    mks_result_t due_scan_results [$];
    plan_entry_t directed_plan [$];
    int          mismatches  = 0;
    int          quiet_cycles = 0;
    int          rx_pause     = 0;
    bit          idle_en      = 1'b1;

    matrix_keypad_scanner i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_row_levels   (s_row_levels),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_drive (m_column_drive),
        .m_key_valid    (m_key_valid),
        .m_key_row      (m_key_row),
        .m_key_column   (m_key_column),
        .m_key_code     (m_key_code)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic mks_result_t predict_scan_tick(input logic [3:0] rows);
        logic [3:0]  rise;
        mks_result_t r;
        int          i;
        rise = rows & ~last_rows;
        r = '0;
        r.column_drive = 4'b0001 << scan_col;
        for (i = 0; i < ROW_COUNT; i++) begin
            if (rise[i]) begin
                if (holdoff_left[i] == 16'd0) begin
                    r.key_valid = 1'b1;
                    r.key_row   = i[1:0];   // later rows overwrite: highest wins
                end
                holdoff_left[i] = scan_debounce;
            end else if (holdoff_left[i] != 16'd0) begin
                holdoff_left[i] = holdoff_left[i] - 16'd1;
            end
        end
        if (r.key_valid) begin
            r.key_column = scan_col;
            r.key_code   = KEY_LEGEND[{r.key_row, scan_col}][6:0];
        end
        // zero dwell behaves like one
        if (dwell_left <= 16'd1) begin
            scan_col   = scan_col + 2'd1;
            dwell_left = scan_dwell;
        end else begin
            dwell_left = dwell_left - 16'd1;
        end
        last_rows = rows;
        return r;
    endfunction

    function automatic void plan_tick(input logic [3:0] rows);
        plan_entry_t e;
        e = '{kind: PLAN_TICK, rows: rows, debounce: '0, dwell: '0, known: 1'b0,
              result: '0};
        directed_plan.push_back(e);
    endfunction

    function automatic void plan_known(input logic [3:0] rows, input logic [3:0] drive,
                                       input logic hit, input logic [1:0] row,
                                       input logic [1:0] col, input logic [6:0] code);
        plan_entry_t e;
        e = '{kind: PLAN_TICK, rows: rows, debounce: '0, dwell: '0, known: 1'b1,
              result: '{column_drive: drive, key_valid: hit, key_row: row,
                        key_column: col, key_code: code}};
        directed_plan.push_back(e);
    endfunction

    function automatic void plan_config(input logic [15:0] debounce, input logic [15:0] dwell);
        plan_entry_t e;
        e = '{kind: PLAN_CONFIG, rows: '0, debounce: debounce, dwell: dwell, known: 1'b0,
              result: '0};
        directed_plan.push_back(e);
    endfunction

    task automatic send_tick(input logic [3:0] rows, input bit known,
                             input mks_result_t typed);
        int          gap;
        mks_result_t predicted;
        gap = idle_en ? $urandom_range(0, 3) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_row_levels <= rows;
        predicted = predict_scan_tick(rows);
        due_scan_results.push_back(known ? typed : predicted);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_scan_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // writes both registers back to back; block must be idle
    task automatic write_scan_config(input logic [15:0] debounce, input logic [15:0] dwell);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= debounce;
        @(negedge aclk);
        cfg_index <= REG_DWELL;
        cfg_wdata <= dwell;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        scan_debounce = debounce;
        scan_dwell    = dwell;
    endtask

    // receiver: hold m_ready low for the drawn pause after each result item
    always @(negedge aclk) begin
        if (rx_pause != 0) begin
            m_ready <= 1'b0;
            rx_pause = rx_pause - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        mks_result_t want;
        if (aresetn && m_valid && m_ready) begin
            rx_pause = idle_en ? $urandom_range(0, 3) : 0;
            if (due_scan_results.size() == 0) begin
                $error("unexpected result item: drive %b key_valid %b",
                       m_column_drive, m_key_valid);
                mismatches++;
            end else begin
                want = due_scan_results.pop_front();
                if (m_column_drive !== want.column_drive) begin
                    $error("column_drive: expected %b, got %b", want.column_drive,
                           m_column_drive);
                    mismatches++;
                end
                if (m_key_valid !== want.key_valid) begin
                    $error("key_valid: expected %b, got %b", want.key_valid, m_key_valid);
                    mismatches++;
                end
                if (m_key_row !== want.key_row) begin
                    $error("key_row: expected %0d, got %0d", want.key_row, m_key_row);
                    mismatches++;
                end
                if (m_key_column !== want.key_column) begin
                    $error("key_column: expected %0d, got %0d", want.key_column,
                           m_key_column);
                    mismatches++;
                end
                if (m_key_code !== want.key_code) begin
                    $error("key_code: expected %h, got %h", want.key_code, m_key_code);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [3:0]  held_rows;
        logic [15:0] deb;
        logic [15:0] dwl;
        int          pick;
        int          phase;
        int          n;
        int          k;

        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_row_levels = '0;
        m_ready      = 1'b0;

        scan_debounce = DEBOUNCE_RESET;
        scan_dwell    = DWELL_RESET;
        dwell_left    = DWELL_RESET;
        scan_col      = 2'd0;
        last_rows     = 4'h0;
        for (k = 0; k < ROW_COUNT; k++) holdoff_left[k] = 16'd0;

        // reset defaults: all rows at once reports the highest row (row 3), a quick
        // re-press inside the hold-off window is dropped
        plan_known(4'h0, 4'b0001, 1'b0, 2'd0, 2'd0, 7'h00);
        plan_known(4'hF, 4'b0001, 1'b1, 2'd3, 2'd0, 7'h2A); // '*'
        plan_known(4'h0, 4'b0001, 1'b0, 2'd0, 2'd0, 7'h00);
        plan_known(4'hF, 4'b0001, 1'b0, 2'd0, 2'd0, 7'h00);
        // no debounce, advance every tick once the old dwell runs out
        plan_config(16'd0, 16'd0);
        plan_tick(4'h0); plan_tick(4'h1); plan_tick(4'h0); plan_tick(4'h2);
        plan_tick(4'h4); plan_tick(4'h8); plan_tick(4'h0); plan_tick(4'hF);
        plan_tick(4'h0); plan_tick(4'hF); plan_tick(4'h0); plan_tick(4'h8);
        plan_config(16'hFFFF, 16'hFFFF);
        plan_tick(4'h0); plan_tick(4'hF); plan_tick(4'h0); plan_tick(4'hF);
        plan_tick(4'h1); plan_tick(4'h0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == PLAN_CONFIG) begin
                wait_drained();
                write_scan_config(directed_plan[k].debounce, directed_plan[k].dwell);
            end else begin
                send_tick(directed_plan[k].rows, directed_plan[k].known,
                          directed_plan[k].result);
            end
        end

        held_rows = 4'h0;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin deb = 16'd0;     dwl = 16'd1;     end
                1:       begin deb = 16'hFFFF;  dwl = 16'd2;     end
                2:       begin deb = 16'd3;     dwl = 16'hFFFF;  end
                3:       begin deb = 16'd1;     dwl = 16'd0;     end
                default: begin
                    deb = 16'($urandom_range(0, 10));
                    dwl = 16'($urandom_range(0, 6));
                end
            endcase
            wait_drained();
            write_scan_config(deb, dwl);
            idle_en = (phase % 3) != 2;
            for (n = 0; n < PHASE_TICKS; n++) begin
                // mostly single keys going down, held, coming up; some noise
                pick = $urandom_range(0, 9);
                if (pick < 5) held_rows = held_rows ^ (4'b0001 << $urandom_range(0, 3));
                else if (pick >= 8) held_rows = 4'($urandom_range(0, 15));
                send_tick(held_rows, 1'b0, '0);
                if (phase == 4 && n == PHASE_TICKS / 2) wait_drained();
            end
        end

        wait_drained();
        repeat (3) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
